[rtl/core/vaa_pkg.sv]
// ----------------------------------------------------------------------------
// vaa_pkg - shared types and constants for vector_add_activation
// Word layouts, activation codes, register indexes and the exp/tanh tables.
// ----------------------------------------------------------------------------
package vaa_pkg;

  localparam int DataW  = 16;
  localparam int FracW  = 8;
  localparam int Segs   = 64;
  localparam int SegW   = $clog2(Segs);
  localparam int IdxW   = $clog2(Segs + 1);
  localparam int QShift = 16 - FracW;

  localparam int ExpLen    = 16 * (1 << FracW);
  localparam int TanhLen   = 8 * (1 << FracW);
  localparam int ExpStepW  = $clog2(ExpLen / Segs);
  localparam int TanhStepW = $clog2(TanhLen / Segs);

  localparam int MishSplit      = (6 * (1 << FracW) + 9) / 10;
  localparam int SeluScaleQ16   = 68859;
  localparam int SeluScaleAlpha = 115219;

  typedef struct packed {
    logic signed [DataW-1:0] first_value;
    logic signed [DataW-1:0] second_value;
    logic                    last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_value;
    logic                    last_out;
  } out_word_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RELU    = 3'd1,
    ACT_RELU_SQ = 3'd2,
    ACT_TANH    = 3'd3,
    ACT_SIGMOID = 3'd4,
    ACT_SELU    = 3'd5,
    ACT_SWISH   = 3'd6,
    ACT_MISH    = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    REG_ACT_MODE  = 2'd0,
    REG_FIRST_EN  = 2'd1,
    REG_SECOND_EN = 2'd2
  } cfg_reg_t;

  typedef logic [Segs:0][16:0] rom_t;

  function automatic logic [63:0] square_q40(logic [63:0] a);
    logic [63:0] hi, lo, mid;
    hi  = a >> 20;
    lo  = a & ((64'd1 << 20) - 64'd1);
    mid = 64'd2 * hi * lo + ((lo * lo) >> 20);
    return hi * hi + (mid >> 20);
  endfunction

  // Unsigned quotient by shift and subtract; table build only.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table build at elaboration: e^-t by series and four squarings, tanh from it.
  function automatic rom_t build_rom(logic is_tanh);
    logic [63:0] one40, sum, term, ev, den, tv;
    rom_t        r;
    one40 = 64'd1 << 40;
    r     = '0;
    for (int k = 0; k <= Segs; k++) begin
      sum  = one40;
      term = one40;
      for (int j = 1; j <= 40; j++) begin
        if (term != 64'd0) begin
          term = udiv64(term * 64'(k), 64'(Segs) * 64'(j));
          if (j % 2 == 1) sum = sum - term;
          else            sum = sum + term;
        end
      end
      for (int s = 0; s < 4; s++) sum = square_q40(sum);
      ev = (sum + (64'd1 << 23)) >> 24;
      if (ev > 64'd65536) ev = 64'd65536;
      if (sum > one40) sum = one40;
      den = one40 + sum;
      tv  = udiv64(((one40 - sum) << 16) + (den >> 1), den);
      r[k] = is_tanh ? tv[16:0] : ev[16:0];
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM  = build_rom(1'b0);
  localparam rom_t TANH_ROM = build_rom(1'b1);

  // Rescale by 2^16, rounding half away from zero.
  function automatic logic signed [47:0] rnd16(logic signed [47:0] v);
    logic [47:0] mag, m;
    mag = v[47] ? 48'(-v) : 48'(v);
    m   = (mag + 48'd32768) >> 16;
    return v[47] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [DataW-1:0] sat16(logic signed [47:0] v);
    if (v > 48'sd32767)       return 16'sh7fff;
    else if (v < -48'sd32768) return 16'sh8000;
    else                      return v[DataW-1:0];
  endfunction

endpackage

[rtl/core/vector_add_activation.sv]
// ----------------------------------------------------------------------------
// vector_add_activation - element-wise add with selectable activation
// Adds two Q7.8 operands and applies none/relu/relu^2/tanh/sigmoid/selu/
// swish/mish, saturating the result to Q7.8.
// ----------------------------------------------------------------------------
// One word enters per clock and one result word leaves per clock while the
// output is not stalled. From input to output register a word passes the
// reciprocal unit, a divisor set-up stage followed by a pipelined restoring
// divider of 17 stages (one quotient bit each), that sits between four front
// stages (add, table read, linear interpolation, squaring) and three back
// stages (ratio product, final product, rounding and saturation). The whole
// pipe advances together and holds while a result waits on out_ready, so a
// stall neither drops nor repeats a word. Configuration is taken on any cycle
// with cfg_we; the mode and operand enables are sampled as a word enters.
module vector_add_activation
  import vaa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  localparam int DivSteps = 17;

  typedef struct packed {
    logic signed [16:0] x;
    act_t               mode;
    logic               last;
  } base_t;

  typedef struct packed {
    base_t             b;
    logic signed [15:0] ye;   // result of modes finished early
    logic [17:0]       num;   // mish numerator
  } carry_t;

  typedef struct packed {
    logic [19:0] rem;
    logic [16:0] low;
    logic [18:0] d;
    logic [16:0] q;
    carry_t      c;
  } div_t;

  // configuration
  act_t act_mode_r;
  logic first_enable_r, second_enable_r;

  // pipeline
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v6_r, v7_r, out_valid_r;
  logic [DivSteps:0] dv_r;

  base_t b1_r, b2_r, b3_r, b4_r, b6_r, b7_r;
  base_t b1_nxt;
  logic [16:0] eb2_r, tb2_r, eb2_nxt, tb2_nxt;
  logic signed [17:0] ed2_r, td2_r, ed2_nxt, td2_nxt;
  logic [ExpStepW-1:0] ef2_r, ef2_nxt;
  logic [TanhStepW-1:0] tf2_r, tf2_nxt;
  logic [16:0] e3_r, th3_r, e3_nxt, th3_nxt;
  logic [16:0] e4_r, sq4_r, sq4_nxt;
  logic signed [15:0] ye4_r, ye4_nxt, ye6_r, ye7_r, ye6_nxt;
  div_t div_r [0:DivSteps];
  div_t div_nxt [0:DivSteps];
  div_t div0_nxt;
  logic [17:0] m6_r, m6_nxt;
  logic split6_r, split7_r, split6_nxt;
  logic signed [35:0] prod7_r;
  out_word_t out_r, out_nxt;

  // stage 2 helpers
  logic [16:0] ax;
  logic [SegW-1:0] e_idx, t_idx;
  // stage 3 helpers
  logic signed [24:0] pe, pt, ei, ti;
  // stage 4 helpers
  logic [33:0] sqp;
  logic [15:0] r4;
  logic [31:0] rr;
  logic [16:0] tt;
  logic [32:0] sp;
  logic [33:0] sm;
  logic signed [47:0] yv4;
  // stage 5 helpers
  logic [18:0] n5;
  logic [32:0] numer;
  // stage 6 helpers
  logic [16:0] rq, sig;
  logic [34:0] nr;
  logic [17:0] tq;
  // output helpers
  logic signed [47:0] rp, yo;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // config writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_mode_r      <= ACT_NONE;
      first_enable_r  <= 1'b1;
      second_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ACT_MODE:  act_mode_r      <= act_t'(cfg_data);
        REG_FIRST_EN:  first_enable_r  <= cfg_data[0];
        REG_SECOND_EN: second_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: exact sum, one bit wider than the operands
  always_comb begin
    b1_nxt.x    = (first_enable_r ? 17'(in_data.first_value) : 17'sd0)
                + (second_enable_r ? 17'(in_data.second_value) : 17'sd0);
    b1_nxt.mode = act_mode_r;
    b1_nxt.last = in_data.last_in;
  end

  // stage 2: table reads for e^-|x| and tanh|x|
  always_comb begin
    ax    = b1_r.x[16] ? 17'(-b1_r.x) : 17'(b1_r.x);
    e_idx = ax[ExpStepW +: SegW];
    t_idx = ax[TanhStepW +: SegW];
    if (ax >= 17'(ExpLen)) begin
      eb2_nxt = EXP_ROM[Segs];
      ed2_nxt = '0;
      ef2_nxt = '0;
    end else begin
      eb2_nxt = EXP_ROM[{1'b0, e_idx}];
      ed2_nxt = $signed({1'b0, EXP_ROM[IdxW'({1'b0, e_idx}) + IdxW'(1)]})
              - $signed({1'b0, EXP_ROM[{1'b0, e_idx}]});
      ef2_nxt = ax[ExpStepW-1:0];
    end
    if (ax >= 17'(TanhLen)) begin
      tb2_nxt = TANH_ROM[Segs];
      td2_nxt = '0;
      tf2_nxt = '0;
    end else begin
      tb2_nxt = TANH_ROM[{1'b0, t_idx}];
      td2_nxt = $signed({1'b0, TANH_ROM[IdxW'({1'b0, t_idx}) + IdxW'(1)]})
              - $signed({1'b0, TANH_ROM[{1'b0, t_idx}]});
      tf2_nxt = ax[TanhStepW-1:0];
    end
  end

  // stage 3: interpolation, slope term truncated toward zero
  always_comb begin
    pe = ed2_r * $signed({1'b0, ef2_r});
    pt = td2_r * $signed({1'b0, tf2_r});
    ei = (pe < 0) ? -((-pe) >>> ExpStepW) : (pe >>> ExpStepW);
    ti = (pt < 0) ? -((-pt) >>> TanhStepW) : (pt >>> TanhStepW);
    e3_nxt  = 17'($signed({8'b0, eb2_r}) + ei);
    th3_nxt = 17'($signed({8'b0, tb2_r}) + ti);
  end

  // stage 4: e^2 for mish, and the modes that need no reciprocal
  always_comb begin
    sqp     = 34'(e3_r) * 34'(e3_r);
    sq4_nxt = 17'((sqp + 34'd32768) >> 16);
    r4      = b3_r.x[16] ? 16'd0 : b3_r.x[15:0];
    rr      = 32'(r4) * 32'(r4);
    tt      = 17'((18'(th3_r) + 18'd128) >> QShift);
    sp      = 33'(r4) * 33'(SeluScaleQ16);
    sm      = 34'(17'd65536 - e3_r) * 34'(SeluScaleAlpha);
    case (b3_r.mode)
      ACT_NONE:    yv4 = 48'(b3_r.x);
      ACT_RELU:    yv4 = b3_r.x[16] ? 48'sd0 : 48'(b3_r.x);
      ACT_RELU_SQ: yv4 = $signed(48'((33'(rr) + 33'd128) >> FracW));
      ACT_TANH:    yv4 = b3_r.x[16] ? -$signed(48'(tt)) : $signed(48'(tt));
      ACT_SELU: begin
        if (!b3_r.x[16] && (b3_r.x != 17'sd0))
          yv4 = $signed(48'((sp + 33'd32768) >> 16));
        else
          yv4 = -$signed(48'((sm + (34'd1 << 23)) >> (32 - FracW)));
      end
      default:     yv4 = '0;
    endcase
    ye4_nxt = sat16(yv4);
  end

  // stage 5: divisor and numerator; divider input is 2^32 + d/2
  always_comb begin
    n5 = 19'(sq4_r) + 19'({e4_r, 1'b0});
    div0_nxt.c.b  = b4_r;
    div0_nxt.c.ye = ye4_r;
    if (b4_r.mode == ACT_MISH && b4_r.x[16]) begin
      div0_nxt.d     = n5 + 19'd131072;
      div0_nxt.c.num = n5[17:0];
    end else if (b4_r.mode == ACT_MISH) begin
      div0_nxt.d     = 19'd65536 + 19'({e4_r, 1'b0}) + 19'({sq4_r, 1'b0});
      div0_nxt.c.num = 18'({sq4_r, 1'b0});
    end else begin
      div0_nxt.d     = 19'd65536 + 19'(e4_r);
      div0_nxt.c.num = '0;
    end
    numer = (33'd1 << 32) + 33'(div0_nxt.d >> 1);
    div0_nxt.rem = 20'(numer[32:17]);
    div0_nxt.low = numer[16:0];
    div0_nxt.q   = '0;
  end

  // reciprocal: one restoring step per stage
  always_comb begin
    div_nxt[0] = div0_nxt;
    for (int j = 0; j < DivSteps; j++) begin
      div_nxt[j+1]     = div_r[j];
      div_nxt[j+1].low = div_r[j].low << 1;
      div_nxt[j+1].rem = {div_r[j].rem[18:0], div_r[j].low[16]};
      if (div_nxt[j+1].rem >= {1'b0, div_r[j].d}) begin
        div_nxt[j+1].rem = div_nxt[j+1].rem - {1'b0, div_r[j].d};
        div_nxt[j+1].q   = {div_r[j].q[15:0], 1'b1};
      end else begin
        div_nxt[j+1].q   = {div_r[j].q[15:0], 1'b0};
      end
    end
  end

  // stage 6: sigmoid, mish ratio
  always_comb begin
    rq  = div_r[DivSteps].q;
    sig = div_r[DivSteps].c.b.x[16] ? 17'(17'd65536 - rq) : rq;
    nr  = 35'(div_r[DivSteps].c.num) * 35'(rq);
    tq  = 18'((nr + 35'd32768) >> 16);
    split6_nxt = div_r[DivSteps].c.b.x <= -17'(MishSplit);
    ye6_nxt    = div_r[DivSteps].c.ye;
    case (div_r[DivSteps].c.b.mode)
      ACT_MISH: m6_nxt = (div_r[DivSteps].c.b.x[16] && !split6_nxt) ? {rq, 1'b0} : tq;
      ACT_SIGMOID: begin
        m6_nxt  = {1'b0, sig};
        ye6_nxt = sat16($signed(48'((18'(sig) + 18'd128) >> QShift)));
      end
      default:  m6_nxt = {1'b0, sig};
    endcase
  end

  // output: round the product, finish mish, saturate
  always_comb begin
    rp = rnd16(48'(prod7_r));
    case (b7_r.mode)
      ACT_SWISH: yo = rp;
      ACT_MISH:  yo = split7_r ? rp : (48'(b7_r.x) - rp);
      default:   yo = 48'(ye7_r);
    endcase
    out_nxt.out_value = sat16(yo);
    out_nxt.last_out  = b7_r.last;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      dv_r <= '0;   v6_r <= 1'b0; v7_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dv_r        <= {dv_r[DivSteps-1:0], v4_r};
      v6_r        <= dv_r[DivSteps];
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      b1_r  <= b1_nxt;
      b2_r  <= b1_r;
      eb2_r <= eb2_nxt; ed2_r <= ed2_nxt; ef2_r <= ef2_nxt;
      tb2_r <= tb2_nxt; td2_r <= td2_nxt; tf2_r <= tf2_nxt;
      b3_r  <= b2_r;
      e3_r  <= e3_nxt;  th3_r <= th3_nxt;
      b4_r  <= b3_r;
      e4_r  <= e3_r;    sq4_r <= sq4_nxt; ye4_r <= ye4_nxt;
      for (int j = 0; j <= DivSteps; j++) div_r[j] <= div_nxt[j];
      b6_r     <= div_r[DivSteps].c.b;
      m6_r     <= m6_nxt;
      split6_r <= split6_nxt;
      ye6_r    <= ye6_nxt;
      b7_r     <= b6_r;
      split7_r <= split6_r;
      ye7_r    <= ye6_r;
      prod7_r  <= b6_r.x * $signed({1'b0, m6_r});
      out_r    <= out_nxt;
    end
  end

endmodule

[tb/sv/vector_add_activation_test.sv]
// ----------------------------------------------------------------------------
// vector_add_activation_test - self-checking bench for vector_add_activation
// Drives operand words through all eight activations and both operand
// enables, and checks every result word against a fixed-point predictor
// with its own exp/tanh tables, under random stalls on both channels.
// ----------------------------------------------------------------------------
module vector_add_activation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vaa_pkg::*;

  localparam int        NSEG       = 64;
  localparam int        FRAC       = 8;
  localparam int        PIPE_DEPTH = 25;   // input to output register
  localparam int        RAND_WORDS = 400;
  localparam int        QUIET_TAIL = 60;   // last words with no idling
  localparam logic [1:0] REG_SPARE = 2'd3; // no register behind this index

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  vector_add_activation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: own copy of the settings and of the two tables
  // --------------------------------------------------------------------------
  act_t        mode_now = ACT_NONE;
  logic        first_on = 1'b1;
  logic        second_on = 1'b1;
  longint      exp_tbl [0:NSEG];
  longint      tanh_tbl[0:NSEG];

  function automatic longint unsigned sq40(longint unsigned a);
    longint unsigned hi, lo, mid;
    hi  = a >> 20;
    lo  = a & ((64'd1 << 20) - 1);
    mid = 2 * hi * lo + ((lo * lo) >> 20);
    return hi * hi + (mid >> 20);
  endfunction

  // e^-t by alternating series at t = k/64 then squared four times (t*16)
  task automatic fill_tables();
    longint unsigned one40, s, term, ev, den;
    one40 = 64'd1 << 40;
    for (int k = 0; k <= NSEG; k++) begin
      s    = one40;
      term = one40;
      for (int j = 1; j <= 40 && term != 0; j++) begin
        term = term * longint'(k) / (longint'(NSEG) * longint'(j));
        if (j % 2 == 1) s = s - term;
        else            s = s + term;
      end
      for (int r = 0; r < 4; r++) s = sq40(s);
      ev = (s + (64'd1 << 23)) >> 24;
      if (ev > 64'd65536) ev = 64'd65536;
      exp_tbl[k] = longint'(ev);
      if (s > one40) s = one40;
      den = one40 + s;
      tanh_tbl[k] = longint'((((one40 - s) << 16) + den / 2) / den);
    end
  endtask

  // shift right, rounding half away from zero
  function automatic longint rshr(longint v, int s);
    longint m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint interp(bit use_tanh, longint u, longint span);
    longint len, scaled, idx, rem, lo_v, hi_v;
    len = span * (longint'(1) << FRAC);
    if (u >= len) return use_tanh ? tanh_tbl[NSEG] : exp_tbl[NSEG];
    scaled = u * NSEG;
    idx    = scaled / len;
    rem    = scaled % len;
    lo_v   = use_tanh ? tanh_tbl[idx] : exp_tbl[idx];
    hi_v   = use_tanh ? tanh_tbl[idx + 1] : exp_tbl[idx + 1];
    return lo_v + ((hi_v - lo_v) * rem) / len;
  endfunction

  function automatic longint exp_of_neg(longint u);
    return interp(1'b0, u, 16);
  endfunction

  function automatic longint inv32(longint d);
    if (d <= 0) return longint'(1) << 32;
    return ((longint'(1) << 32) + d / 2) / d;
  endfunction

  function automatic longint logistic16(longint x);
    if (x >= 0) return inv32(65536 + exp_of_neg(x));
    return 65536 - inv32(65536 + exp_of_neg(-x));
  endfunction

  function automatic longint mish_fx(longint x);
    longint e, n, t, g, q, q2;
    if (x <= -longint'(MishSplit)) begin
      e = exp_of_neg(-x);
      n = rshr(e * e, 16) + 2 * e;
      t = rshr(n * inv32(n + 2 * 65536), 16);
      return rshr(x * t, 16);
    end
    if (x >= 0) begin
      q  = exp_of_neg(x);
      q2 = rshr(q * q, 16);
      g  = rshr(2 * q2 * inv32(65536 + 2 * q + 2 * q2), 16);
    end else begin
      e = exp_of_neg(-x);
      n = rshr(e * e, 16) + 2 * e;
      g = 2 * inv32(n + 2 * 65536);
    end
    return x - rshr(x * g, 16);
  endfunction

  function automatic longint activated(longint x);
    longint t;
    case (mode_now)
      ACT_RELU:    return (x < 0) ? 0 : x;
      ACT_RELU_SQ: return (x < 0) ? 0 : rshr(x * x, FRAC);
      ACT_TANH: begin
        t = rshr(interp(1'b1, (x < 0) ? -x : x, 8), 16 - FRAC);
        return (x < 0) ? -t : t;
      end
      ACT_SIGMOID: return rshr(logistic16(x), 16 - FRAC);
      ACT_SELU: begin
        if (x > 0) return rshr(x * SeluScaleQ16, 16);
        return rshr((exp_of_neg(-x) - 65536) * SeluScaleAlpha, 32 - FRAC);
      end
      ACT_SWISH:   return rshr(x * logistic16(x), 16);
      ACT_MISH:    return mish_fx(x);
      default:     return x;
    endcase
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    longint    x, y;
    out_word_t r;
    x = (first_on ? longint'(w.first_value) : 0) +
        (second_on ? longint'(w.second_value) : 0);
    y = activated(x);
    if (y > 32767)  y = 32767;
    if (y < -32768) y = -32768;
    r.out_value = 16'(y);
    r.last_out  = w.last_in;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  out_word_t pending[$];
  int        errors = 0;

  task automatic report_bad(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        report_bad($sformatf("unexpected word value=%h last=%b",
                             out_data.out_value, out_data.last_out));
      end else begin
        want = pending.pop_front();
        if (out_data.out_value !== want.out_value)
          report_bad($sformatf("out_value got %h want %h",
                               out_data.out_value, want.out_value));
        if (out_data.last_out !== want.last_out)
          report_bad($sformatf("last_out got %b want %b",
                               out_data.last_out, want.last_out));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure bursts, one long hold-off, calm tail
  // --------------------------------------------------------------------------
  bit hold_off_req = 1'b0;
  bit calm = 1'b0;

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (3 * PIPE_DEPTH) @(posedge clk);  // long enough to fill the pipe
        hold_off_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // offer one word; expectation pushed when accepted. Called at a rising edge.
  task automatic send_word(in_word_t w, bit typed, logic signed [15:0] typed_val);
    out_word_t e;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = predict_word(w);
    if (typed) e.out_value = typed_val;
    pending.push_back(e);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ACT_MODE:  mode_now  = act_t'(val);
      REG_FIRST_EN:  first_on  = val[0];
      REG_SECOND_EN: second_on = val[0];
      default: ;  // ignored by the block
    endcase
  endtask

  // drains first so that the pipe holds no word under the old setting
  task automatic apply_setting(act_t m, logic f, logic s);
    if (m == mode_now && f == first_on && s == second_on) return;
    drain();
    if (m != mode_now)  write_reg(REG_ACT_MODE, m);
    if (f != first_on)  write_reg(REG_FIRST_EN, {2'b0, f});
    if (s != second_on) write_reg(REG_SECOND_EN, {2'b0, s});
  endtask

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0, 1:    return 16'($urandom);
      2, 3:    return 16'($signed($urandom_range(0, 2047)) - 1024);  // +-4.0
      4:       return 16'($signed($urandom_range(0, 255)) - 128);    // +-0.5
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  typedef struct {
    act_t              mode;
    logic              f_en;
    logic              s_en;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic              last;
    bit                typed;
    logic signed [15:0] val;
  } row_t;

  // directed rows; val is given only where it is obvious
  row_t rows[] = '{
    '{ACT_NONE,    1, 1, 16'sh7fff, 16'sh7fff, 1, 1, 16'sh7fff},  // high saturation
    '{ACT_NONE,    1, 1, 16'sh8000, 16'sh8000, 0, 1, 16'sh8000},  // low saturation
    '{ACT_NONE,    1, 1, 16'sh0100, 16'sh0080, 1, 1, 16'sh0180},
    '{ACT_NONE,    0, 1, 16'sh1234, 16'sh0100, 0, 1, 16'sh0100},  // first off
    '{ACT_NONE,    1, 0, 16'sh0200, 16'sh7fff, 1, 1, 16'sh0200},  // second off
    '{ACT_NONE,    0, 0, 16'sh7fff, 16'sh8000, 0, 1, 16'sh0000},  // both off
    '{ACT_RELU,    1, 1, 16'shffff, 16'sh0000, 1, 1, 16'sh0000},
    '{ACT_RELU,    1, 1, 16'sh0200, 16'sh0100, 0, 1, 16'sh0300},
    '{ACT_RELU_SQ, 1, 1, 16'sh7fff, 16'sh7fff, 1, 1, 16'sh7fff},  // square saturates
    '{ACT_RELU_SQ, 1, 1, 16'sh0100, 16'sh0100, 0, 1, 16'sh0400},
    '{ACT_TANH,    1, 1, 16'sh0000, 16'sh0000, 1, 1, 16'sh0000},
    '{ACT_TANH,    1, 1, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh0000},  // beyond table end
    '{ACT_TANH,    1, 1, 16'shff00, 16'sh0000, 1, 0, 16'sh0000},  // odd symmetry
    '{ACT_SIGMOID, 1, 1, 16'sh0000, 16'sh0000, 0, 1, 16'sh0080},
    '{ACT_SIGMOID, 1, 1, 16'sh8000, 16'sh8000, 1, 0, 16'sh0000},  // exp past table
    '{ACT_SIGMOID, 1, 1, 16'sh0100, 16'sh0000, 0, 0, 16'sh0000},
    '{ACT_SELU,    1, 1, 16'sh0000, 16'sh0000, 1, 1, 16'sh0000},  // zero takes exp side
    '{ACT_SELU,    1, 1, 16'sh0100, 16'sh0000, 0, 0, 16'sh0000},
    '{ACT_SELU,    1, 1, 16'sh8000, 16'sh8000, 1, 0, 16'sh0000},
    '{ACT_SWISH,   1, 1, 16'sh0200, 16'sh0000, 0, 0, 16'sh0000},
    '{ACT_SWISH,   1, 1, 16'shff00, 16'sh0000, 1, 0, 16'sh0000},
    '{ACT_MISH,    1, 1, 16'shff66, 16'sh0000, 0, 0, 16'sh0000},  // -154: on the split
    '{ACT_MISH,    1, 1, 16'shff67, 16'sh0000, 1, 0, 16'sh0000},  // just above it
    '{ACT_MISH,    1, 1, 16'sh0000, 16'sh0000, 0, 0, 16'sh0000},
    '{ACT_MISH,    1, 1, 16'sh0400, 16'sh0000, 1, 0, 16'sh0000},
    '{ACT_MISH,    1, 1, 16'sh8000, 16'sh8000, 0, 0, 16'sh0000}
  };

  initial begin
    in_word_t w;
    act_t     m;
    fill_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_SPARE, 3'd7);  // must leave all settings alone

    foreach (rows[i]) begin
      apply_setting(rows[i].mode, rows[i].f_en, rows[i].s_en);
      w = '{first_value: rows[i].a, second_value: rows[i].b, last_in: rows[i].last};
      send_word(w, rows[i].typed, rows[i].val);
      maybe_gap();
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 40 == 0) begin
        m = act_t'($urandom_range(0, 7));
        apply_setting(m, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      end
      // back-to-back words against a long receiver hold-off
      if (n == 100) hold_off_req = 1'b1;
      // sender waits for every outstanding result
      if (n == 200) drain();
      if (n == RAND_WORDS - QUIET_TAIL) calm = 1'b1;
      w.first_value  = rand_operand();
      w.second_value = rand_operand();
      w.last_in      = $urandom_range(0, 1);
      send_word(w, 1'b0, '0);
      if (!hold_off_req) maybe_gap();
    end

    drain();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else             $display("== FAIL ==");
    $finish;
  end

endmodule
